// File: sv/aes_pkg.sv
package aes_pkg;

	// One input beat and one result beat.
	typedef struct packed {
		logic        cmd;
		logic [63:0] key_hi;
		logic [63:0] key_lo;
		logic [63:0] data_hi;
		logic [63:0] data_lo;
	} aes_in_t;

	typedef struct packed {
		logic [63:0] result_hi;
		logic [63:0] result_lo;
	} aes_out_t;

	// Payload handed from one cell to the next.
	typedef struct packed {
		logic         cmd;
		logic [127:0] key;
		logic [127:0] state;
	} aes_pipe_t;

	localparam logic CMD_ENCRYPT = 1'b0;
	localparam logic CMD_DECRYPT = 1'b1;

	localparam int NUM_ROUNDS = 10;

	typedef logic [7:0] sbox_t [256];

	localparam sbox_t SBOX = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	// The inverse table is built from the forward one at elaboration.
	function automatic sbox_t make_inv_sbox();
		sbox_t r;
		for (int i = 0; i < 256; i++) begin
			r[SBOX[i]] = 8'(i);
		end
		return r;
	endfunction

	localparam sbox_t INV_SBOX = make_inv_sbox();

	// Round constants, indexed by round number; entry zero is unused.
	typedef logic [7:0] rcon_t [NUM_ROUNDS + 1];
	localparam rcon_t RCON = '{
		8'h00, 8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
	};

	// Byte i of a 128-bit block, byte 0 in the top bits.
	function automatic logic [7:0] get_byte(input logic [127:0] x, input int i);
		return x[127 - 8 * i -: 8];
	endfunction

	function automatic logic [7:0] xt(input logic [7:0] a);
		return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] p;
		logic [7:0] x;
		p = 8'h00;
		x = a;
		for (int i = 0; i < 8; i++) begin
			if (b[i]) begin
				p = p ^ x;
			end
			x = xt(x);
		end
		return p;
	endfunction

	// Rotate, substitute and add the round constant to the last key word.
	function automatic logic [31:0] key_g(input logic [31:0] w, input logic [7:0] rc);
		return {SBOX[w[23:16]] ^ rc, SBOX[w[15:8]], SBOX[w[7:0]], SBOX[w[31:24]]};
	endfunction

	// One step of the key schedule forward.
	function automatic logic [127:0] key_fwd(input logic [127:0] k, input logic [7:0] rc);
		logic [31:0] w0, w1, w2, w3;
		w0 = k[127:96] ^ key_g(k[31:0], rc);
		w1 = k[95:64] ^ w0;
		w2 = k[63:32] ^ w1;
		w3 = k[31:0] ^ w2;
		return {w0, w1, w2, w3};
	endfunction

	// One step of the key schedule backward: the previous round key.
	function automatic logic [127:0] key_back(input logic [127:0] n, input logic [7:0] rc);
		logic [31:0] p0, p1, p2, p3;
		p1 = n[95:64] ^ n[127:96];
		p2 = n[63:32] ^ n[95:64];
		p3 = n[31:0] ^ n[63:32];
		p0 = n[127:96] ^ key_g(p3, rc);
		return {p0, p1, p2, p3};
	endfunction

endpackage

// File: sv/aes_key_cell.sv
module aes_key_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              valid_in,
	input  aes_pkg::aes_pipe_t pipe_in,
	input  logic [7:0]        rcon,
	output logic              valid_out,
	output aes_pkg::aes_pipe_t pipe_out
);
	import aes_pkg::*;

	aes_pipe_t nxt;

	// Decrypt beats walk the key forward to the last round key; encrypt beats wait.
	always_comb begin
		nxt = pipe_in;
		if (pipe_in.cmd == CMD_DECRYPT) begin
			nxt.key = key_fwd(pipe_in.key, rcon);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_out <= 1'b0;
		end else begin
			valid_out <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		pipe_out <= nxt;
	end

endmodule

// File: sv/aes_round_cell.sv
module aes_round_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              valid_in,
	input  aes_pkg::aes_pipe_t pipe_in,
	input  logic [7:0]        rcon_enc,
	input  logic [7:0]        rcon_dec,
	input  logic              last,
	output logic              valid_out,
	output aes_pkg::aes_pipe_t pipe_out
);
	import aes_pkg::*;

	logic [127:0] key_e, key_d, st_e, st_d;
	logic [7:0]   te [16];
	logic [7:0]   td [16];
	aes_pipe_t    nxt;

	// Forward round: SubBytes, ShiftRows, MixColumns unless last, then the next key.
	always_comb begin
		key_e = key_fwd(pipe_in.key, rcon_enc);
		for (int c = 0; c < 4; c++) begin
			for (int i = 0; i < 4; i++) begin
				te[i + 4 * c] = SBOX[get_byte(pipe_in.state, i + 4 * ((c + i) % 4))];
			end
		end
		for (int c = 0; c < 4; c++) begin
			if (last) begin
				st_e[127 - 32 * c -: 32] = {te[4 * c], te[4 * c + 1], te[4 * c + 2], te[4 * c + 3]};
			end else begin
				st_e[127 - 32 * c -: 8] = xt(te[4 * c]) ^ xt(te[4 * c + 1]) ^ te[4 * c + 1]
					^ te[4 * c + 2] ^ te[4 * c + 3];
				st_e[119 - 32 * c -: 8] = te[4 * c] ^ xt(te[4 * c + 1]) ^ xt(te[4 * c + 2])
					^ te[4 * c + 2] ^ te[4 * c + 3];
				st_e[111 - 32 * c -: 8] = te[4 * c] ^ te[4 * c + 1] ^ xt(te[4 * c + 2])
					^ xt(te[4 * c + 3]) ^ te[4 * c + 3];
				st_e[103 - 32 * c -: 8] = xt(te[4 * c]) ^ te[4 * c] ^ te[4 * c + 1]
					^ te[4 * c + 2] ^ xt(te[4 * c + 3]);
			end
		end
		st_e = st_e ^ key_e;
	end

	// Inverse round: InvShiftRows, InvSubBytes, the previous key, InvMixColumns unless last.
	always_comb begin
		key_d = key_back(pipe_in.key, rcon_dec);
		for (int c = 0; c < 4; c++) begin
			for (int i = 0; i < 4; i++) begin
				td[i + 4 * c] = INV_SBOX[get_byte(pipe_in.state, i + 4 * ((c - i + 4) % 4))]
					^ get_byte(key_d, i + 4 * c);
			end
		end
		for (int c = 0; c < 4; c++) begin
			if (last) begin
				st_d[127 - 32 * c -: 32] = {td[4 * c], td[4 * c + 1], td[4 * c + 2], td[4 * c + 3]};
			end else begin
				st_d[127 - 32 * c -: 8] = gmul(td[4 * c], 8'd14) ^ gmul(td[4 * c + 1], 8'd11)
					^ gmul(td[4 * c + 2], 8'd13) ^ gmul(td[4 * c + 3], 8'd9);
				st_d[119 - 32 * c -: 8] = gmul(td[4 * c], 8'd9) ^ gmul(td[4 * c + 1], 8'd14)
					^ gmul(td[4 * c + 2], 8'd11) ^ gmul(td[4 * c + 3], 8'd13);
				st_d[111 - 32 * c -: 8] = gmul(td[4 * c], 8'd13) ^ gmul(td[4 * c + 1], 8'd9)
					^ gmul(td[4 * c + 2], 8'd14) ^ gmul(td[4 * c + 3], 8'd11);
				st_d[103 - 32 * c -: 8] = gmul(td[4 * c], 8'd11) ^ gmul(td[4 * c + 1], 8'd13)
					^ gmul(td[4 * c + 2], 8'd9) ^ gmul(td[4 * c + 3], 8'd14);
			end
		end
	end

	// Pick the direction of this beat.
	always_comb begin
		nxt.cmd = pipe_in.cmd;
		if (pipe_in.cmd == CMD_DECRYPT) begin
			nxt.key   = key_d;
			nxt.state = st_d;
		end else begin
			nxt.key   = key_e;
			nxt.state = st_e;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_out <= 1'b0;
		end else begin
			valid_out <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		pipe_out <= nxt;
	end

endmodule

// File: sv/aes128_block_cipher.sv
// AES-128 encrypt and decrypt, fully pipelined: a new beat is taken on every clock edge
// with start high (busy is always low). Its result is on the result port with done
// once the beat has passed the key cell registers and then the round cell registers. The
// first ten cells run the key schedule forward for decrypt beats, and the next ten cells
// each perform one cipher round. The result must be captured in its single strobe cycle,
// since the block cannot hold it.
module aes128_block_cipher (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  aes_pkg::aes_in_t  item,
	output logic              busy,
	output logic              done,
	output aes_pkg::aes_out_t result
);
	import aes_pkg::*;

	logic      kv [NUM_ROUNDS + 1];
	aes_pipe_t kp [NUM_ROUNDS + 1];
	logic      rv [NUM_ROUNDS + 1];
	aes_pipe_t rp [NUM_ROUNDS + 1];

	assign busy = 1'b0;

	// Entry of the key chain.
	assign kv[0]       = start;
	assign kp[0].cmd   = item.cmd;
	assign kp[0].key   = {item.key_hi, item.key_lo};
	assign kp[0].state = {item.data_hi, item.data_lo};

	for (genvar k = 1; k <= NUM_ROUNDS; k++) begin : g_key
		aes_key_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.valid_in  (kv[k - 1]),
			.pipe_in   (kp[k - 1]),
			.rcon      (RCON[k]),
			.valid_out (kv[k]),
			.pipe_out  (kp[k])
		);
	end

	// Initial key addition: first round key for encrypt, last for decrypt.
	assign rv[0]       = kv[NUM_ROUNDS];
	assign rp[0].cmd   = kp[NUM_ROUNDS].cmd;
	assign rp[0].key   = kp[NUM_ROUNDS].key;
	assign rp[0].state = kp[NUM_ROUNDS].state ^ kp[NUM_ROUNDS].key;

	for (genvar k = 1; k <= NUM_ROUNDS; k++) begin : g_round
		aes_round_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.valid_in  (rv[k - 1]),
			.pipe_in   (rp[k - 1]),
			.rcon_enc  (RCON[k]),
			.rcon_dec  (RCON[NUM_ROUNDS + 1 - k]),
			.last      (k == NUM_ROUNDS),
			.valid_out (rv[k]),
			.pipe_out  (rp[k])
		);
	end

	assign done             = rv[NUM_ROUNDS];
	assign result.result_hi = rp[NUM_ROUNDS].state[127:64];
	assign result.result_lo = rp[NUM_ROUNDS].state[63:0];

`ifndef SYNTH
	// A result beat always stems from an earlier start that passed through both chains.
	a_done_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, 20)) else $error("done without matching start");

	// A beat leaving the key chain comes out of the first round cell in the next cycle.
	a_chain_link: assert property (@(posedge clk) disable iff (!arst_n)
		kv[NUM_ROUNDS] |=> rv[1]) else $error("beat lost between chains");

	// The round chain output follows the key chain output, through every round cell.
	a_round_span: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(kv[NUM_ROUNDS], 10)) else $error("round chain length mismatch");
`endif

endmodule
